FILE: hdl/i2c_master_bit_engine_assert.svh
// ----------------------------------------------------------------------------
// I2C master bit engine assertion macros
// Clocked property macros used by the checker file of the block.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH

// A property checked at every rising edge, switched off while reset is high.
`define I2CMBE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A property checked at every rising edge, reset included.
`define I2CMBE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/i2cmbe_pkg.sv
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Transfer types and opcodes shared by the engine's modules, and the sequencer's state record.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

  localparam int DATA_BITS = 8;
  localparam int IDX_W     = $clog2(DATA_BITS + 1);

  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_STOP  = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_WAIT  = 3'd4;
  localparam logic [2:0] OP_ACK   = 3'd5;
  localparam logic [2:0] OP_NACK  = 3'd6;

  typedef struct packed {
    logic                 command_valid;
    logic [2:0]           opcode;
    logic [DATA_BITS-1:0] write_data;
    logic                 ack_after_read;
    logic                 sda_in;
  } cmd_t;

  typedef struct packed {
    logic                 scl_level;
    logic                 sda_release;
    logic                 busy_res;
    logic                 done_res;
    logic [DATA_BITS-1:0] read_data;
    logic                 ack_received;
  } res_t;

  typedef struct packed {
    logic [2:0]           active_command;
    logic [IDX_W-1:0]     bit_index;
    logic [2:0]           phase;
    logic [DATA_BITS-1:0] shift_data;
    logic                 scl;
    logic                 sda;
    logic                 ack_flag;
    logic                 busy_flag;
    logic [DATA_BITS-1:0] read_reg;
    logic                 ack_level;
  } state_t;

endpackage

FILE: hdl/i2cmbe_seq.sv
// ----------------------------------------------------------------------------
// I2C master bit engine sequencer
// Holds the line state and works out one half-bit interval per enabled cycle.
// ----------------------------------------------------------------------------
module i2cmbe_seq
  import i2cmbe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  cmd_t item,
  output res_t result
);

  localparam logic [IDX_W-1:0] BIT_COUNT = IDX_W'(DATA_BITS);

  state_t state;
  state_t state_next;
  logic   busy_out;
  logic   done;

  always_comb begin
    state_next = state;
    busy_out   = 1'b0;
    done       = 1'b0;
    if (!state.busy_flag && item.command_valid && item.opcode <= OP_NACK) begin
      state_next.active_command = item.opcode;
      state_next.phase          = '0;
      state_next.bit_index      = '0;
      state_next.shift_data     = (item.opcode == OP_WRITE) ? item.write_data : '0;
      if (item.opcode == OP_READ) begin
        state_next.ack_level = !item.ack_after_read;
      end else if (item.opcode == OP_ACK) begin
        state_next.ack_level = 1'b0;
      end else if (item.opcode == OP_NACK) begin
        state_next.ack_level = 1'b1;
      end
      state_next.busy_flag = 1'b1;
    end
    if (state_next.busy_flag) begin
      busy_out = 1'b1;
      unique case (state_next.active_command)
        OP_START: begin
          priority if (state_next.phase == 3'd0) begin
            {state_next.scl, state_next.sda} = 2'b11;
          end else if (state_next.phase == 3'd1) begin
            {state_next.scl, state_next.sda} = 2'b10;
          end else begin
            {state_next.scl, state_next.sda} = 2'b00;
            done = 1'b1;
          end
          state_next.phase = state_next.phase + 3'd1;
        end
        OP_STOP: begin
          priority if (state_next.phase == 3'd0) begin
            {state_next.scl, state_next.sda} = 2'b00;
          end else if (state_next.phase == 3'd1) begin
            {state_next.scl, state_next.sda} = 2'b10;
          end else begin
            {state_next.scl, state_next.sda} = 2'b11;
            done = 1'b1;
          end
          state_next.phase = state_next.phase + 3'd1;
        end
        OP_WRITE: begin
          priority if (state_next.phase == 3'd0) begin
            state_next.scl   = 1'b0;
            state_next.sda   = state_next.shift_data[DATA_BITS-1];
            state_next.phase = 3'd1;
          end else if (state_next.phase == 3'd1) begin
            state_next.scl        = 1'b1;
            state_next.shift_data = {state_next.shift_data[DATA_BITS-2:0], 1'b0};
            state_next.bit_index  = state_next.bit_index + 1'b1;
            state_next.phase      = (state_next.bit_index >= BIT_COUNT) ? 3'd2 : 3'd0;
          end else begin
            {state_next.scl, state_next.sda} = 2'b01;
            done = 1'b1;
          end
        end
        OP_READ: begin
          priority if (state_next.phase == 3'd0) begin
            {state_next.scl, state_next.sda} = 2'b11;
            state_next.shift_data = {state_next.shift_data[DATA_BITS-2:0], item.sda_in};
            state_next.phase      = 3'd1;
          end else if (state_next.phase == 3'd1) begin
            {state_next.scl, state_next.sda} = 2'b01;
            state_next.bit_index = state_next.bit_index + 1'b1;
            state_next.phase     = (state_next.bit_index >= BIT_COUNT) ? 3'd2 : 3'd0;
          end else if (state_next.phase == 3'd2) begin
            {state_next.scl, state_next.sda} = {1'b0, state_next.ack_level};
            state_next.phase = 3'd3;
          end else if (state_next.phase == 3'd3) begin
            {state_next.scl, state_next.sda} = {1'b1, state_next.ack_level};
            state_next.phase = 3'd4;
          end else begin
            {state_next.scl, state_next.sda} = {1'b0, state_next.ack_level};
            state_next.read_reg = state_next.shift_data;
            done = 1'b1;
          end
        end
        OP_WAIT: begin
          priority if (state_next.phase == 3'd0) begin
            {state_next.scl, state_next.sda} = 2'b01;
            state_next.phase = 3'd1;
          end else if (state_next.phase == 3'd1) begin
            {state_next.scl, state_next.sda} = 2'b11;
            state_next.ack_flag = !item.sda_in;
            state_next.phase    = item.sda_in ? 3'd3 : 3'd2;
          end else if (state_next.phase == 3'd2) begin
            {state_next.scl, state_next.sda} = 2'b01;
            done = 1'b1;
          end else if (state_next.phase == 3'd3) begin
            {state_next.scl, state_next.sda} = 2'b00;
            state_next.phase = 3'd4;
          end else if (state_next.phase == 3'd4) begin
            {state_next.scl, state_next.sda} = 2'b10;
            state_next.phase = 3'd5;
          end else begin
            {state_next.scl, state_next.sda} = 2'b11;
            done = 1'b1;
          end
        end
        default: begin
          priority if (state_next.phase == 3'd0) begin
            {state_next.scl, state_next.sda} = {1'b0, state_next.ack_level};
          end else if (state_next.phase == 3'd1) begin
            {state_next.scl, state_next.sda} = {1'b1, state_next.ack_level};
          end else begin
            {state_next.scl, state_next.sda} = {1'b0, state_next.ack_level};
            done = 1'b1;
          end
          state_next.phase = state_next.phase + 3'd1;
        end
      endcase
      if (done) begin
        state_next.busy_flag = 1'b0;
        state_next.phase     = '0;
        state_next.bit_index = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.active_command <= '0;
      state.bit_index      <= '0;
      state.phase          <= '0;
      state.shift_data     <= '0;
      state.scl            <= 1'b1;
      state.sda            <= 1'b1;
      state.ack_flag       <= 1'b0;
      state.busy_flag      <= 1'b0;
      state.read_reg       <= '0;
      state.ack_level      <= 1'b1;
    end else if (en) begin
      state <= state_next;
    end
  end

  assign result.scl_level    = state_next.scl;
  assign result.sda_release  = state_next.sda;
  assign result.busy_res     = busy_out;
  assign result.done_res     = done;
  assign result.read_data    = state_next.read_reg;
  assign result.ack_received = state_next.ack_flag;

endmodule

FILE: hdl/i2c_master_bit_engine.sv
// A command is taken into the input register, and the sequencer's step is registered in the result register.
// One half-bit interval per clock while a command is held and res_stall does not hold the result.
// A result waiting on res_stall holds the input register, so cmd_stall rises once it is full.
// Reset (rst, synchronous) releases SCL and SDA high and empties both registers.
// ----------------------------------------------------------------------------
// I2C master bit engine
// Input register, interval sequencer and result register of the line engine.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine
  import i2cmbe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  logic hold_valid;
  cmd_t hold;
  logic advance;
  res_t step_res;

  assign advance   = !res_valid || !res_stall;
  assign cmd_stall = hold_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!cmd_stall) begin
      hold_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!cmd_stall) begin
      hold <= cmd;
    end
  end

  i2cmbe_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .en     (hold_valid && advance),
    .item   (hold),
    .result (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_valid && advance) begin
      res <= step_res;
    end
  end

endmodule

FILE: hdl/i2cmbe_checker.sv
// ----------------------------------------------------------------------------
// I2C master bit engine checker
// Port-level properties of the engine, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "i2c_master_bit_engine_assert.svh"

module i2cmbe_checker
  import i2cmbe_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic cmd_valid,
  input logic cmd_stall,
  input cmd_t cmd,
  input logic res_valid,
  input logic res_stall,
  input res_t res
);

  `I2CMBE_ASSERT(a_done_in_busy, res_valid && res.done_res |-> res.busy_res, "done outside a command")
  `I2CMBE_ASSERT(a_res_hold, res_valid && res_stall |=> res_valid && $stable(res), "stalled result changed")
  `I2CMBE_ASSERT(a_cmd_hold, cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd), "stalled command changed")
  `I2CMBE_ASSERT_ALWAYS(a_reset_empty, rst |=> !res_valid, "result valid after reset")

endmodule

bind i2c_master_bit_engine i2cmbe_checker u_checker (.*);
